// ----- hdl/tlt_pkg.sv -----
// Shared types, widths and the root search step for the thick line expander.
package tlt_pkg;

   localparam int COORD_W = 20;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int LW_W    = 8;
   localparam int COLOR_W = 32;
   localparam int S_W     = 2 * DIFF_W;
   localparam int NUM_W   = DIFF_W + LW_W;
   localparam int SQ_W    = 2 * NUM_W;
   localparam int ACC_W   = SQ_W + 2;
   localparam int ROOT_W  = LW_W;
   localparam int OFF_W   = LW_W + 1;
   localparam int STEPS   = ROOT_W;
   localparam int CORNER_W = 3;
   localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [OFF_W-1:0]   offset_type;

   typedef struct packed {
      coord_type            sx;
      coord_type            sy;
      coord_type            ex;
      coord_type            ey;
      logic [COLOR_W-1:0]   color;
      logic                 path;
   } seg_type;

   typedef struct packed {
      seg_type              seg;
      logic                 neg_ox;
      logic                 neg_oy;
      logic                 zero;
      logic [S_W-1:0]       s;
      logic [SQ_W-1:0]      numx2;
      logic [SQ_W-1:0]      numy2;
   } front_type;

   typedef struct packed {
      logic [ACC_W-1:0]     p;
      logic [ACC_W-1:0]     q_s;
      logic [ROOT_W-1:0]    root;
   } root_type;

   typedef struct packed {
      seg_type              seg;
      offset_type           ox;
      offset_type           oy;
   } emit_type;

   // One bit of root = floor(num / sqrt(s)), tracking root^2 * s and root * s.
   function automatic root_type root_step(root_type cur, logic [S_W-1:0] s,
                                          logic [SQ_W-1:0] num2, logic [2:0] bit_idx);
      root_type         nxt;
      logic [ACC_W-1:0] s_ext;
      logic [ACC_W-1:0] cand;
      logic [3:0]       sh1;
      logic [3:0]       sh2;
      nxt   = cur;
      s_ext = ACC_W'(s);
      sh1   = {1'b0, bit_idx} + 4'd1;
      sh2   = {bit_idx, 1'b0};
      cand  = cur.p + (cur.q_s << sh1) + (s_ext << sh2);
      if (cand <= ACC_W'(num2)) begin
         nxt.p             = cand;
         nxt.q_s           = cur.q_s + (s_ext << bit_idx);
         nxt.root[bit_idx] = 1'b1;
      end
      return nxt;
   endfunction

endpackage

// ----- hdl/tlt_req_if.sv -----
// Segment request channel.
interface tlt_req_if;
   tlt_pkg::coord_type                  start_x;
   tlt_pkg::coord_type                  start_y;
   tlt_pkg::coord_type                  end_x;
   tlt_pkg::coord_type                  end_y;
   logic [tlt_pkg::LW_W-1:0]            line_width;
   logic [tlt_pkg::COLOR_W-1:0]         rgba;
   logic                                on_path;
   logic                                valid;
   logic                                ready;

   modport source (output start_x, start_y, end_x, end_y, line_width, rgba, on_path, valid,
                   input ready);
   modport sink (input start_x, start_y, end_x, end_y, line_width, rgba, on_path, valid,
                 output ready);
endinterface

// ----- hdl/tlt_rsp_if.sv -----
// Vertex response channel.
interface tlt_rsp_if;
   tlt_pkg::coord_type                  vertex_x;
   tlt_pkg::coord_type                  vertex_y;
   logic [tlt_pkg::COLOR_W-1:0]         vertex_rgba;
   logic                                to_path_list;
   logic [tlt_pkg::CORNER_W-1:0]        corner;
   logic                                last_vertex;
   logic                                valid;
   logic                                ready;

   modport source (output vertex_x, vertex_y, vertex_rgba, to_path_list, corner, last_vertex,
                   valid, input ready);
   modport sink (input vertex_x, vertex_y, vertex_rgba, to_path_list, corner, last_vertex,
                 valid, output ready);
endinterface

// ----- hdl/tlt_front.sv -----
// Front stages: deltas, magnitudes, squared length and squared numerators.
module tlt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  tlt_pkg::seg_type          in_seg,
   input  logic [tlt_pkg::LW_W-1:0]  in_width,
   output logic                      out_valid,
   output tlt_pkg::front_type        out_data
);
   import tlt_pkg::*;

   logic                     a_v_ff, b_v_ff, c_v_ff;
   seg_type                  a_seg_ff, b_seg_ff;
   logic [LW_W-1:0]          a_w_ff;
   logic signed [DIFF_W-1:0] a_dx_ff, a_dy_ff;
   logic signed [DIFF_W-1:0] dx_in, dy_in;
   logic [DIFF_W-1:0]        adx, ady;
   logic                     b_neg_ox_ff, b_neg_oy_ff;
   logic [S_W-1:0]           b_sqx_ff, b_sqy_ff;
   logic [NUM_W-1:0]         b_nx_ff, b_ny_ff;
   front_type                c_ff;
   logic [S_W-1:0]           s_in;

   assign dx_in = DIFF_W'(in_seg.ex) - DIFF_W'(in_seg.sx);
   assign dy_in = DIFF_W'(in_seg.ey) - DIFF_W'(in_seg.sy);
   assign adx   = a_dx_ff[DIFF_W-1] ? DIFF_W'(-a_dx_ff) : DIFF_W'(a_dx_ff);
   assign ady   = a_dy_ff[DIFF_W-1] ? DIFF_W'(-a_dy_ff) : DIFF_W'(a_dy_ff);
   assign s_in  = b_sqx_ff + b_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_seg_ff    <= in_seg;
         a_w_ff      <= in_width;
         a_dx_ff     <= dx_in;
         a_dy_ff     <= dy_in;
         b_seg_ff    <= a_seg_ff;
         b_neg_ox_ff <= !a_dy_ff[DIFF_W-1] && (a_dy_ff != '0);
         b_neg_oy_ff <= a_dx_ff[DIFF_W-1];
         b_sqx_ff    <= S_W'(adx) * S_W'(adx);
         b_sqy_ff    <= S_W'(ady) * S_W'(ady);
         b_nx_ff     <= NUM_W'(ady) * NUM_W'(a_w_ff);
         b_ny_ff     <= NUM_W'(adx) * NUM_W'(a_w_ff);
         c_ff.seg    <= b_seg_ff;
         c_ff.neg_ox <= b_neg_ox_ff;
         c_ff.neg_oy <= b_neg_oy_ff;
         c_ff.zero   <= (s_in == '0);
         c_ff.s      <= s_in;
         c_ff.numx2  <= SQ_W'(b_nx_ff) * SQ_W'(b_nx_ff);
         c_ff.numy2  <= SQ_W'(b_ny_ff) * SQ_W'(b_ny_ff);
      end
   end

   assign out_valid = c_v_ff;
   assign out_data  = c_ff;
endmodule

// ----- hdl/tlt_solve.sv -----
// Bit-per-stage search for both offset magnitudes, then signed rounded offsets.
module tlt_solve (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  tlt_pkg::front_type    in_data,
   output logic                  out_valid,
   output tlt_pkg::emit_type     out_data
);
   import tlt_pkg::*;

   front_type        data_ff [STEPS];
   root_type         rx_ff   [STEPS];
   root_type         ry_ff   [STEPS];
   logic [STEPS-1:0] v_ff;
   front_type        src_data [STEPS];
   root_type         src_rx   [STEPS];
   root_type         src_ry   [STEPS];
   logic [STEPS-1:0] src_v;
   logic             out_v_ff;
   emit_type         out_ff;
   front_type        last;
   logic [ROOT_W:0]  qx1, qy1;
   offset_type       mx, my;

   genvar k;
   generate
      for (k = 0; k < STEPS; k++) begin : g_step
         if (k == 0) begin : g_first
            assign src_data[k] = in_data;
            assign src_rx[k]   = '0;
            assign src_ry[k]   = '0;
            assign src_v[k]    = in_valid;
         end else begin : g_next
            assign src_data[k] = data_ff[k-1];
            assign src_rx[k]   = rx_ff[k-1];
            assign src_ry[k]   = ry_ff[k-1];
            assign src_v[k]    = v_ff[k-1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en) begin
               v_ff[k] <= src_v[k];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               data_ff[k] <= src_data[k];
               rx_ff[k]   <= root_step(src_rx[k], src_data[k].s, src_data[k].numx2,
                                       3'(STEPS - 1 - k));
               ry_ff[k]   <= root_step(src_ry[k], src_data[k].s, src_data[k].numy2,
                                       3'(STEPS - 1 - k));
            end
         end
      end
   endgenerate

   assign last = data_ff[STEPS-1];
   assign qx1  = {1'b0, rx_ff[STEPS-1].root} + 1'b1;
   assign qy1  = {1'b0, ry_ff[STEPS-1].root} + 1'b1;
   assign mx   = last.zero ? '0 : OFF_W'(qx1 >> 1);
   assign my   = last.zero ? '0 : OFF_W'(qy1 >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= v_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.seg <= last.seg;
         out_ff.ox  <= last.neg_ox ? -mx : mx;
         out_ff.oy  <= last.neg_oy ? -my : my;
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;
endmodule

// ----- hdl/tlt_emit.sv -----
// Holds one segment and sends its six corners through a registered output.
module tlt_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  tlt_pkg::emit_type    item,
   output logic                 take,
   tlt_rsp_if.source            rsp
);
   import tlt_pkg::*;

   logic                  hold_ff;
   emit_type              item_ff;
   logic [CORNER_W-1:0]   corner_ff;
   logic                  out_v_ff;
   coord_type             vx_ff, vy_ff;
   logic [COLOR_W-1:0]    color_ff;
   logic                  path_ff;
   logic [CORNER_W-1:0]   out_corner_ff;
   logic                  adv;
   logic                  use_start;
   logic                  minus;
   coord_type             bx, by;
   offset_type            dxo, dyo;
   coord_type             vx_in, vy_in;

   function automatic coord_type sat_add(coord_type base, offset_type off);
      logic signed [COORD_W:0] sum;
      sum = {base[COORD_W-1], base} + (COORD_W+1)'(off);
      if (sum[COORD_W] != sum[COORD_W-1]) begin
         return sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end
      return sum[COORD_W-1:0];
   endfunction

   assign adv       = hold_ff && (!out_v_ff || rsp.ready);
   assign take      = !hold_ff || (adv && (corner_ff == CORNER_LAST));
   assign use_start = corner_ff inside {3'd0, 3'd1, 3'd3};
   assign minus     = corner_ff inside {3'd0, 3'd3, 3'd5};
   assign bx        = use_start ? item_ff.seg.sx : item_ff.seg.ex;
   assign by        = use_start ? item_ff.seg.sy : item_ff.seg.ey;
   assign dxo       = minus ? -item_ff.ox : item_ff.ox;
   assign dyo       = minus ? -item_ff.oy : item_ff.oy;
   assign vx_in     = sat_add(bx, dxo);
   assign vy_in     = sat_add(by, dyo);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         corner_ff <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         if (adv) begin
            out_v_ff  <= 1'b1;
            corner_ff <= (corner_ff == CORNER_LAST) ? '0 : corner_ff + 1'b1;
         end else if (rsp.ready) begin
            out_v_ff <= 1'b0;
         end
         if (take) begin
            hold_ff <= item_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item;
      end
      if (adv) begin
         vx_ff         <= vx_in;
         vy_ff         <= vy_in;
         color_ff      <= item_ff.seg.color;
         path_ff       <= item_ff.seg.path;
         out_corner_ff <= corner_ff;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.vertex_x     = vx_ff;
   assign rsp.vertex_y     = vy_ff;
   assign rsp.vertex_rgba  = color_ff;
   assign rsp.to_path_list = path_ff;
   assign rsp.corner       = out_corner_ff;
   assign rsp.last_vertex  = (out_corner_ff == CORNER_LAST);
endmodule

// ----- hdl/thick_line_to_triangles.sv -----
// Top level of the thick line to triangle expander.
// Each segment transfer on req yields six vertex transfers on rsp, corners 0 to 5, forming the
// triangles (start-offset, start+offset, end+offset) and (start-offset, end+offset,
// end-offset), where the offset is the rounded unit normal times half the line width and
// coordinates saturate to 20 bits. A segment passes three front stages, eight root search
// stages and one offset stage before it reaches the output holder. The sustained segment
// rate is set by the single vertex output port, which sends the six vertices of a segment
// one at a time; the pipeline keeps taking segments while earlier vertices are still
// waiting and stalls as a whole only when the holder is still busy.
module thick_line_to_triangles (
   input  logic        clock,
   input  logic        reset,
   tlt_req_if.sink     req,
   tlt_rsp_if.source   rsp
);
   import tlt_pkg::*;

   logic       en;
   logic       take;
   seg_type    in_seg;
   logic       f_valid;
   front_type  f_data;
   logic       s_valid;
   emit_type   s_data;

   assign en        = !s_valid || take;
   assign req.ready = en;

   assign in_seg.sx    = req.start_x;
   assign in_seg.sy    = req.start_y;
   assign in_seg.ex    = req.end_x;
   assign in_seg.ey    = req.end_y;
   assign in_seg.color = req.rgba;
   assign in_seg.path  = req.on_path;

   tlt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req.valid),
      .in_seg    (in_seg),
      .in_width  (req.line_width),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   tlt_solve u_solve (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_data   (f_data),
      .out_valid (s_valid),
      .out_data  (s_data)
   );

   tlt_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s_valid),
      .item       (s_data),
      .take       (take),
      .rsp        (rsp)
   );
endmodule

// ----- tb/tlt_tb_if.sv -----
// Testbench-side view of the segment and vertex channels is provided by the RTL interfaces.
interface tlt_tb_clk_if (input logic clock);
   logic reset;
endinterface

// ----- tb/tb_thick_line_to_triangles.sv -----
// Testbench for the thick line expander: directed and random segments, predicted vertices.
module tb_thick_line_to_triangles;
   import tlt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      coord_type          vx;
      coord_type          vy;
      logic [COLOR_W-1:0] color;
      logic               path;
      logic [CORNER_W-1:0] corner;
      logic               last;
   } vertex_type;

   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   tlt_tb_clk_if ctl (.clock(clock));
   wire reset = ctl.reset;
   tlt_req_if req ();
   tlt_rsp_if rsp ();

   vertex_type vertex_queue[$];
   int error_count = 0;
   int idle_count = 0;
   int sent_count = 0;
   bit quiet_mode = 1'b0;
   bit hold_off = 1'b0;
   bit hold_done = 1'b0;

   thick_line_to_triangles dut (.clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint offset_magnitude(longint mag, longint w, longint s);
      longint num2;
      longint n;
      num2 = (mag * w) * (mag * w);
      n = 0;
      for (longint k = 1; k <= 128; k++) begin
         if ((2 * k - 1) * (2 * k - 1) * s <= num2) n = k;
         else break;
      end
      return n;
   endfunction

   function automatic coord_type clamp_coord(longint v);
      if (v > 524287) return coord_type'(524287);
      if (v < -524288) return coord_type'(-524288);
      return coord_type'(v);
   endfunction

   task automatic predict_vertices(coord_type sx, coord_type sy, coord_type ex, coord_type ey,
                                   logic [LW_W-1:0] w, logic [COLOR_W-1:0] color,
                                   logic path);
      longint dx, dy, adx, ady, s, ox, oy;
      longint px[6];
      longint py[6];
      vertex_type v;
      dx = longint'(ex) - longint'(sx);
      dy = longint'(ey) - longint'(sy);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      s = adx * adx + ady * ady;
      ox = 0;
      oy = 0;
      if (s != 0) begin
         ox = offset_magnitude(ady, longint'(w), s);
         oy = offset_magnitude(adx, longint'(w), s);
         if (dy > 0) ox = -ox;
         if (dx < 0) oy = -oy;
      end
      px[0] = sx - ox; py[0] = sy - oy;
      px[1] = sx + ox; py[1] = sy + oy;
      px[2] = ex + ox; py[2] = ey + oy;
      px[3] = sx - ox; py[3] = sy - oy;
      px[4] = ex + ox; py[4] = ey + oy;
      px[5] = ex - ox; py[5] = ey - oy;
      for (int k = 0; k < 6; k++) begin
         v.vx = clamp_coord(px[k]);
         v.vy = clamp_coord(py[k]);
         v.color = color;
         v.path = path;
         v.corner = CORNER_W'(k);
         v.last = (CORNER_W'(k) == CORNER_LAST);
         vertex_queue.push_back(v);
      end
   endtask

   task automatic report_mismatch(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic send_segment(coord_type sx, coord_type sy, coord_type ex, coord_type ey,
                               logic [LW_W-1:0] w, logic [COLOR_W-1:0] color, logic path);
      while (!quiet_mode && $urandom_range(99) < 35) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.start_x <= sx;
      req.start_y <= sy;
      req.end_x <= ex;
      req.end_y <= ey;
      req.line_width <= w;
      req.rgba <= color;
      req.on_path <= path;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      predict_vertices(sx, sy, ex, ey, w, color, path);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic coord_type random_coord();
      case ($urandom_range(3))
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(1023)) - coord_type'(512);
         2: return $urandom_range(1) ? coord_type'(524287 - $urandom_range(300))
                                     : coord_type'(-524288 + $urandom_range(300));
         default: return coord_type'($urandom_range(65535)) - coord_type'(32768);
      endcase
   endfunction

   task automatic send_random_segment();
      coord_type sx, sy;
      sx = random_coord();
      sy = random_coord();
      if ($urandom_range(9) == 0)
         send_segment(sx, sy, sx, sy, LW_W'($urandom), $urandom, 1'($urandom));
      else if ($urandom_range(4) == 0)
         send_segment(sx, sy, sx + coord_type'($urandom_range(7)) - coord_type'(3),
                      sy + coord_type'($urandom_range(7)) - coord_type'(3),
                      LW_W'($urandom), $urandom, 1'($urandom));
      else
         send_segment(sx, sy, random_coord(), random_coord(), LW_W'($urandom), $urandom,
                      1'($urandom));
   endtask

   task automatic test_directed();
      send_segment(0, 0, 160, 0, 8'd32, 32'hFF00_00FF, 1'b0);
      send_segment(0, 0, 0, 160, 8'd32, 32'h00FF_00FF, 1'b1);
      send_segment(0, 0, -160, 0, 8'd255, 32'h0000_FFFF, 1'b0);
      send_segment(0, 0, 0, -160, 8'd255, 32'hFFFF_FFFF, 1'b1);
      send_segment(0, 0, 48, 64, 8'd20, 32'h1234_5678, 1'b0);
      send_segment(0, 0, 1, 1, 8'd1, 32'h0, 1'b1);
      send_segment(100, -100, 100, -100, 8'd255, 32'hDEAD_BEEF, 1'b1);
      send_segment(5, 5, 900, -700, 8'd0, 32'hA5A5_A5A5, 1'b0);
      send_segment(-524288, -524288, 524287, 524287, 8'd255, 32'h5A5A_5A5A, 1'b1);
      send_segment(524287, -524288, -524288, 524287, 8'd255, 32'h0F0F_0F0F, 1'b0);
      send_segment(524287, 524287, 524287, 524000, 8'd255, 32'hF0F0_F0F0, 1'b1);
      send_segment(-524288, -524288, -524000, -524288, 8'd255, 32'h8000_0001, 1'b0);
      send_segment(524287, 0, 524287, 524287, 8'd128, 32'h7FFF_FFFE, 1'b1);
      send_segment(0, 0, 3, 4, 8'd1, 32'h0101_0101, 1'b0);
      send_segment(0, 0, 1, 0, 8'd1, 32'h8080_8080, 1'b1);
   endtask

   task automatic test_random();
      for (int i = 0; i < 150; i++) send_random_segment();
      quiet_mode = 1'b1;
      for (int i = 0; i < 60; i++) send_random_segment();
      quiet_mode = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int i = 0; i < 80; i++) send_random_segment();
   endtask

   always begin
      @(negedge clock);
      if (hold_off && !hold_done) begin
         rsp.ready <= 1'b0;
         repeat (300) @(negedge clock);
         hold_done = 1'b1;
      end else begin
         rsp.ready <= quiet_mode || ($urandom_range(99) >= 35);
      end
   end

   always @(posedge clock) begin
      vertex_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (vertex_queue.size() == 0) begin
            report_mismatch("vertex with no expectation");
         end else begin
            want = vertex_queue.pop_front();
            if (rsp.vertex_x !== want.vx)
               report_mismatch($sformatf("vertex_x %0d want %0d", rsp.vertex_x, want.vx));
            if (rsp.vertex_y !== want.vy)
               report_mismatch($sformatf("vertex_y %0d want %0d", rsp.vertex_y, want.vy));
            if (rsp.vertex_rgba !== want.color)
               report_mismatch($sformatf("vertex_rgba %h want %h", rsp.vertex_rgba, want.color));
            if (rsp.to_path_list !== want.path) report_mismatch("to_path_list");
            if (rsp.corner !== want.corner)
               report_mismatch($sformatf("corner %0d want %0d", rsp.corner, want.corner));
            if (rsp.last_vertex !== want.last) report_mismatch("last_vertex");
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      ctl.reset = 1'b1;
      req.valid = 1'b0;
      req.start_x = '0;
      req.start_y = '0;
      req.end_x = '0;
      req.end_y = '0;
      req.line_width = '0;
      req.rgba = '0;
      req.on_path = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      ctl.reset <= 1'b0;
      test_directed();
      test_random();
      test_backpressure();
      req.valid <= 1'b0;
      while (vertex_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && vertex_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
